>>> hw/rtl/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Field widths, padding constants, round constants, initial hash values,
// sequencer states and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 3;
   localparam int INDEX_W = 3;

   localparam logic [COUNT_W-1:0] MAX_BYTES  = 3'd4;
   localparam logic [7:0]         PAD_MARK   = 8'h80;
   localparam int                 LEN_POS    = 56;
   localparam logic [3:0]         LEN_WORD   = 4'(LEN_POS / 4);
   localparam logic [3:0]         LAST_WORD  = 4'd15;
   localparam logic [5:0]         LAST_ROUND = 6'd63;
   localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd7;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_COMPRESS,
      ST_FINAL,
      ST_OUT
   } state_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
      return (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return ror32(x, 5'd2) ^ ror32(x, 5'd13) ^ ror32(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return ror32(x, 5'd6) ^ ror32(x, 5'd11) ^ ror32(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return ror32(x, 5'd7) ^ ror32(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return ror32(x, 5'd17) ^ ror32(x, 5'd19) ^ (x >> 10);
   endfunction

   // keep the top n bytes of a word
   function automatic logic [31:0] top_mask(input logic [COUNT_W-1:0] n);
      logic [31:0] m;
      case (n)
         3'd0:    m = 32'h00000000;
         3'd1:    m = 32'hff000000;
         3'd2:    m = 32'hffff0000;
         3'd3:    m = 32'hffffff00;
         default: m = 32'hffffffff;
      endcase
      return m;
   endfunction

endpackage

>>> hw/rtl/sha256_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine channels
// Request channel carrying message bytes and response channel carrying
// digest words, both with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic                               valid;
   logic                               ready;
   logic [sha256_pkg::WORD_W-1:0]      data_word;
   logic [sha256_pkg::COUNT_W-1:0]     byte_count;
   logic                               last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha256_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sha256_pkg::WORD_W-1:0]      digest_word;
   logic [sha256_pkg::INDEX_W-1:0]     word_index;
   logic                               digest_last;

   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

>>> hw/rtl/sha256_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streaming SHA-256 with one compression round per cycle.
// ----------------------------------------------------------------------------
// req_chan takes one word per handshake: up to four message bytes from the
// top of data_word, byte_count of them valid (counts above four act as four),
// and last_word to close the message. rsp_chan returns the eight digest
// words, word_index 0 first, digest_last on the eighth.
// The word that fills a 64-byte block holds req_chan.ready low while the
// block runs its 64 rounds through the shared round unit and the result is
// folded into the hash.
// After a last word the engine pads, one padding word at a time (3 to 18 in
// all), interleaved with one or two more compressions, then loads one digest
// word per cycle into the output register while rsp_chan.ready allows. It
// takes words again once the eighth digest word is loaded, even while that
// word still waits.
// A stalled receiver holds the engine in its output phase.
// Reset restores the initial hash values, clears the byte count and drops
// any pending output.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
   input  logic              clock,
   input  logic              reset,
   sha256_req_if.sink        req_chan,
   sha256_rsp_if.source      rsp_chan
);

   sha256_pkg::state_type state_ff, state_in;

   logic [31:0] w_ff    [16];
   logic [31:0] hash_ff [8];
   logic [31:0] rv_ff   [8];

   logic [31:0] part_ff, part_in;
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [5:0]  round_ff, round_in;
   logic [60:0] total_ff, total_in;
   logic        last_ff, last_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic [2:0]  oidx_ff, oidx_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;
   logic [2:0]  rsp_idx_ff;

   logic        push_en;
   logic [31:0] push_word;
   logic        rsp_load;
   logic        hash_restart;
   logic        load_rv;

   logic [2:0]  cnt_sat;
   logic [2:0]  sum;
   logic [31:0] part_m;
   logic [31:0] data_m;
   logic [63:0] merged;
   logic [31:0] mark_word;

   logic [31:0] sched_new;
   logic [31:0] t1, t2;

   assign req_chan.ready       = (state_ff == sha256_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_idx_ff;
   assign rsp_chan.digest_last = (rsp_idx_ff == sha256_pkg::LAST_INDEX);

   // byte packing
   assign cnt_sat   = (req_chan.byte_count > sha256_pkg::MAX_BYTES) ?
                      sha256_pkg::MAX_BYTES : req_chan.byte_count;
   assign sum       = {1'b0, pcnt_ff} + cnt_sat;
   assign part_m    = part_ff & sha256_pkg::top_mask({1'b0, pcnt_ff});
   assign data_m    = req_chan.data_word & sha256_pkg::top_mask(cnt_sat);
   assign merged    = {part_m, 32'h0} | ({data_m, 32'h0} >> {pcnt_ff, 3'b000});
   assign mark_word = part_m | ({sha256_pkg::PAD_MARK, 24'h0} >> {pcnt_ff, 3'b000});

   // round unit
   assign sched_new = sha256_pkg::small_sigma1(w_ff[14]) + w_ff[9] +
                      sha256_pkg::small_sigma0(w_ff[1]) + w_ff[0];
   assign t1 = rv_ff[7] + sha256_pkg::big_sigma1(rv_ff[4]) +
               ((rv_ff[4] & rv_ff[5]) ^ (~rv_ff[4] & rv_ff[6])) +
               sha256_pkg::ROUND_K[round_ff] + w_ff[0];
   assign t2 = sha256_pkg::big_sigma0(rv_ff[0]) +
               ((rv_ff[0] & rv_ff[1]) ^ (rv_ff[0] & rv_ff[2]) ^ (rv_ff[1] & rv_ff[2]));

   assign load_rv = (state_in == sha256_pkg::ST_COMPRESS) &&
                    (state_ff != sha256_pkg::ST_COMPRESS);

   always_comb begin
      state_in     = state_ff;
      push_en      = 1'b0;
      push_word    = merged[63:32];
      part_in      = part_ff;
      pcnt_in      = pcnt_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      oidx_in      = oidx_ff;
      rsp_load     = 1'b0;
      hash_restart = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               total_in = total_ff + 61'(cnt_sat);
               last_in  = req_chan.last_word;
               pcnt_in  = sum[1:0];
               if (sum[2]) begin
                  push_en = 1'b1;
                  part_in = merged[31:0];
               end else begin
                  part_in = merged[63:32];
               end
               if (sum[2] && wcnt_ff == sha256_pkg::LAST_WORD) begin
                  state_in = sha256_pkg::ST_COMPRESS;
               end else if (req_chan.last_word) begin
                  state_in = sha256_pkg::ST_MARK;
               end
            end
         end
         sha256_pkg::ST_MARK: begin
            push_en   = 1'b1;
            push_word = mark_word;
            pcnt_in   = 2'd0;
            mark_in   = 1'b1;
            state_in  = (wcnt_ff == sha256_pkg::LAST_WORD) ?
                        sha256_pkg::ST_COMPRESS : sha256_pkg::ST_ZERO;
         end
         sha256_pkg::ST_ZERO: begin
            push_en = 1'b1;
            if (wcnt_ff == sha256_pkg::LEN_WORD) begin
               push_word = total_ff[60:29];
               state_in  = sha256_pkg::ST_LEN;
            end else begin
               push_word = 32'h0;
               if (wcnt_ff == sha256_pkg::LAST_WORD) begin
                  state_in = sha256_pkg::ST_COMPRESS;
               end
            end
         end
         sha256_pkg::ST_LEN: begin
            push_en   = 1'b1;
            push_word = {total_ff[28:0], 3'b000};
            len_in    = 1'b1;
            state_in  = sha256_pkg::ST_COMPRESS;
         end
         sha256_pkg::ST_COMPRESS: begin
            round_in = round_ff + 6'd1;
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = sha256_pkg::ST_FINAL;
            end
         end
         sha256_pkg::ST_FINAL: begin
            if (!last_ff) begin
               state_in = sha256_pkg::ST_IDLE;
            end else if (len_ff) begin
               state_in = sha256_pkg::ST_OUT;
            end else if (mark_ff) begin
               state_in = sha256_pkg::ST_ZERO;
            end else begin
               state_in = sha256_pkg::ST_MARK;
            end
         end
         sha256_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               oidx_in  = oidx_ff + 3'd1;
               if (oidx_ff == sha256_pkg::LAST_INDEX) begin
                  state_in     = sha256_pkg::ST_IDLE;
                  hash_restart = 1'b1;
                  total_in     = 61'd0;
                  last_in      = 1'b0;
                  mark_in      = 1'b0;
                  len_in       = 1'b0;
               end
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
      wcnt_in = push_en ? wcnt_ff + 4'd1 : wcnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         pcnt_ff  <= 2'd0;
         wcnt_ff  <= 4'd0;
         round_ff <= 6'd0;
         total_ff <= 61'd0;
         last_ff  <= 1'b0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         oidx_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         pcnt_ff  <= pcnt_in;
         wcnt_ff  <= wcnt_in;
         round_ff <= round_in;
         total_ff <= total_in;
         last_ff  <= last_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   // message schedule window, filled by packed words and rolled by rounds
   always_ff @(posedge clock) begin
      if (state_ff == sha256_pkg::ST_COMPRESS || push_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= (state_ff == sha256_pkg::ST_COMPRESS) ? sched_new : push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rv) begin
         for (int i = 0; i < 8; i++) begin
            rv_ff[i] <= hash_ff[i];
         end
      end else if (state_ff == sha256_pkg::ST_COMPRESS) begin
         rv_ff[7] <= rv_ff[6];
         rv_ff[6] <= rv_ff[5];
         rv_ff[5] <= rv_ff[4];
         rv_ff[4] <= rv_ff[3] + t1;
         rv_ff[3] <= rv_ff[2];
         rv_ff[2] <= rv_ff[1];
         rv_ff[1] <= rv_ff[0];
         rv_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || hash_restart) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha256_pkg::H_INIT[i];
         end
      end else if (state_ff == sha256_pkg::ST_FINAL) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + rv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= hash_ff[oidx_ff];
         rsp_idx_ff  <= oidx_ff;
      end
   end

   // a last word stops intake until the last digest word is loaded
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_word) |=> !req_chan.ready)
      else $error("intake stayed open after a last word");

   // padding leaves no partial block before the digest goes out
   a_out_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_OUT) |-> (wcnt_ff == 4'd0 && pcnt_ff == 2'd0))
      else $error("digest output with a partial block pending");

   // hash fold only after the final round
   a_fold_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_FINAL) |->
         ($past(state_ff) == sha256_pkg::ST_COMPRESS &&
          $past(round_ff) == sha256_pkg::LAST_ROUND))
      else $error("hash fold without a complete round sequence");

endmodule
